>>> src/cmsa_pkg.sv
// Package for the compact-and-merge block: sizes, action codes and the queue entry type.
// Used by cmsa_front, cmsa_back and the top level compact_and_merge_sorted_arrays.
package cmsa_pkg;

    localparam int FIRST_DEPTH  = 32;
    localparam int SECOND_DEPTH = 32;

    localparam int VALUE_W  = 32;
    localparam int ACTION_W = 2;

    localparam int FIRST_AW  = (FIRST_DEPTH > 1) ? $clog2(FIRST_DEPTH) : 1;
    localparam int SECOND_AW = (SECOND_DEPTH > 1) ? $clog2(SECOND_DEPTH) : 1;
    localparam int FIRST_CW  = $clog2(FIRST_DEPTH + 1);
    localparam int SECOND_CW = $clog2(SECOND_DEPTH + 1);
    localparam int TOTAL_W   = $clog2(FIRST_DEPTH + SECOND_DEPTH + 1);

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    localparam logic [VALUE_W-1:0] EMPTY_MARK = '1;

    localparam logic [ACTION_W-1:0] ACT_LOAD_FIRST  = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_LOAD_SECOND = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_RUN         = 2'd2;

    typedef enum logic [1:0] {
        OP_LOAD_FIRST  = 2'd0,
        OP_LOAD_SECOND = 2'd1,
        OP_RUN         = 2'd2
    } t_op;

    typedef struct packed {
        t_op                      op;
        logic signed [VALUE_W-1:0] value;
    } t_cmd;

    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_queue_head;

endpackage

>>> src/cmsa_front.sv
// Front part: accepts input requests, decodes the action and queues the commands.
// Depends on cmsa_pkg; feeds cmsa_back.
module cmsa_front (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    input  logic signed [cmsa_pkg::VALUE_W-1:0]  i_s_tdata,  // value
    input  logic [cmsa_pkg::ACTION_W-1:0]   i_s_tuser,  // action
    output cmsa_pkg::t_queue_head           o_head,
    input  logic                            i_pop
);
    import cmsa_pkg::*;

    t_cmd                r_entry [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wr_ptr, n_wr_ptr;
    logic [QUEUE_AW-1:0] r_rd_ptr, n_rd_ptr;
    logic [QUEUE_CW-1:0] r_fill, n_fill;
    logic                known;
    logic                push;
    t_cmd                cmd_in;

    always_comb begin
        known     = 1'b1;
        cmd_in.op = OP_RUN;
        unique case (i_s_tuser)
            ACT_LOAD_FIRST:  cmd_in.op = OP_LOAD_FIRST;
            ACT_LOAD_SECOND: cmd_in.op = OP_LOAD_SECOND;
            ACT_RUN:         cmd_in.op = OP_RUN;
            default:         known = 1'b0;
        endcase
        cmd_in.value = i_s_tdata;
    end

    assign o_s_tready = (r_fill != QUEUE_CW'(QUEUE_DEPTH));
    assign push       = i_s_tvalid && o_s_tready && known;

    assign o_head.valid = (r_fill != '0);
    assign o_head.cmd   = r_entry[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_fill   = r_fill;
        if (push) begin
            n_wr_ptr = r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = r_rd_ptr + 1'b1;
        end
        if (push && !i_pop) begin
            n_fill = r_fill + 1'b1;
        end else if (!push && i_pop) begin
            n_fill = r_fill - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_fill   <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_entry[r_wr_ptr] <= cmd_in;
        end
    end

endmodule

>>> src/cmsa_back.sv
// Back part: holds both stores and counts, executes loads and runs the two-way merge.
// Depends on cmsa_pkg; takes commands from cmsa_front.
module cmsa_back (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  cmsa_pkg::t_queue_head             i_head,
    output logic                              o_pop,
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    output logic signed [cmsa_pkg::VALUE_W-1:0] o_m_tdata,  // merged_value
    output logic                              o_m_tlast,
    output logic                              o_m_tuser   // count_mismatch
);
    import cmsa_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE  = 2'b01,
        ST_MERGE = 2'b10
    } t_state;

    t_state               r_state, n_state;
    logic [FIRST_CW-1:0]  r_slot_count, n_slot_count;
    logic [FIRST_CW-1:0]  r_kept_count, n_kept_count;
    logic [SECOND_CW-1:0] r_second_count, n_second_count;
    logic [FIRST_CW-1:0]  r_ia, n_ia;
    logic [SECOND_CW-1:0] r_ib, n_ib;
    logic [TOTAL_W-1:0]   r_left, n_left;
    logic                 r_mismatch, n_mismatch;

    logic signed [VALUE_W-1:0] r_kept_mem [FIRST_DEPTH];
    logic signed [VALUE_W-1:0] r_second_mem [SECOND_DEPTH];
    logic signed [VALUE_W-1:0] r_rd_a, r_rd_b;

    logic                      kept_we, second_we;
    logic                      emit, take_first, out_free;
    logic signed [VALUE_W-1:0] pick;
    logic [TOTAL_W-1:0]        total;

    logic                      r_m_valid;
    logic signed [VALUE_W-1:0] r_m_data;
    logic                      r_m_last;
    logic                      r_m_mismatch;

    assign out_free = !r_m_valid || i_m_tready;
    assign total    = TOTAL_W'(r_kept_count) + TOTAL_W'(r_second_count);

    always_comb begin
        if (r_ia >= r_kept_count) begin
            take_first = 1'b0;
        end else if (r_ib >= r_second_count) begin
            take_first = 1'b1;
        end else begin
            take_first = (r_rd_a <= r_rd_b);
        end
        pick = take_first ? r_rd_a : r_rd_b;
    end

    always_comb begin
        n_state        = r_state;
        n_slot_count   = r_slot_count;
        n_kept_count   = r_kept_count;
        n_second_count = r_second_count;
        n_ia           = r_ia;
        n_ib           = r_ib;
        n_left         = r_left;
        n_mismatch     = r_mismatch;
        o_pop          = 1'b0;
        kept_we        = 1'b0;
        second_we      = 1'b0;
        emit           = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_head.valid) begin
                    o_pop = 1'b1;
                    unique case (i_head.cmd.op)
                        OP_LOAD_FIRST: begin
                            if (r_slot_count < FIRST_CW'(FIRST_DEPTH)) begin
                                n_slot_count = r_slot_count + 1'b1;
                                if (i_head.cmd.value != EMPTY_MARK &&
                                    r_kept_count < FIRST_CW'(FIRST_DEPTH)) begin
                                    kept_we      = 1'b1;
                                    n_kept_count = r_kept_count + 1'b1;
                                end
                            end
                        end
                        OP_LOAD_SECOND: begin
                            if (r_second_count < SECOND_CW'(SECOND_DEPTH)) begin
                                second_we      = 1'b1;
                                n_second_count = r_second_count + 1'b1;
                            end
                        end
                        OP_RUN: begin
                            n_ia       = '0;
                            n_ib       = '0;
                            n_left     = total;
                            n_mismatch = (SECOND_CW'(r_slot_count - r_kept_count)
                                          != r_second_count);
                            if (total != '0) begin
                                n_state = ST_MERGE;
                            end else begin
                                n_slot_count   = '0;
                                n_kept_count   = '0;
                                n_second_count = '0;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_MERGE: begin
                if (out_free) begin
                    emit   = 1'b1;
                    n_left = r_left - 1'b1;
                    if (take_first) begin
                        n_ia = r_ia + 1'b1;
                    end else begin
                        n_ib = r_ib + 1'b1;
                    end
                    if (r_left == TOTAL_W'(1)) begin
                        n_state        = ST_IDLE;
                        n_slot_count   = '0;
                        n_kept_count   = '0;
                        n_second_count = '0;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_IDLE;
            r_slot_count   <= '0;
            r_kept_count   <= '0;
            r_second_count <= '0;
            r_ia           <= '0;
            r_ib           <= '0;
            r_left         <= '0;
            r_mismatch     <= 1'b0;
            r_m_valid      <= 1'b0;
        end else begin
            r_state        <= n_state;
            r_slot_count   <= n_slot_count;
            r_kept_count   <= n_kept_count;
            r_second_count <= n_second_count;
            r_ia           <= n_ia;
            r_ib           <= n_ib;
            r_left         <= n_left;
            r_mismatch     <= n_mismatch;
            if (emit) begin
                r_m_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_m_data     <= pick;
            r_m_last     <= (r_left == TOTAL_W'(1));
            r_m_mismatch <= r_mismatch;
        end
    end

    // The read ports follow the next head indexes, so the registered head values line up with the registered indexes.
    always_ff @(posedge i_clk) begin
        if (kept_we) begin
            r_kept_mem[r_kept_count[FIRST_AW-1:0]] <= i_head.cmd.value;
        end
        r_rd_a <= r_kept_mem[n_ia[FIRST_AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (second_we) begin
            r_second_mem[r_second_count[SECOND_AW-1:0]] <= i_head.cmd.value;
        end
        r_rd_b <= r_second_mem[n_ib[SECOND_AW-1:0]];
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = r_m_data;
    assign o_m_tlast  = r_m_last;
    assign o_m_tuser  = r_m_mismatch;

endmodule

>>> src/compact_and_merge_sorted_arrays.sv
// Top level of the compact-and-merge block: joins the command queue and the merge engine.
// Depends on cmsa_pkg, cmsa_front and cmsa_back.
//
// The slave channel carries requests: tuser holds the action, tdata the value.
// Action 0 loads one slot of the first sorted array; a value of -1 marks an
// empty slot, which is counted but not kept. Action 1 loads one element of the
// second sorted array. Action 2 starts a run. Action 3 is accepted and ignored.
// Loads beyond a store's depth of 32 are dropped.
// A run emits the merge of the kept values and the second array on the master
// channel, one element per cycle while the receiver is ready, with tlast on the
// final one. On equal values the first array's element goes first. tuser is high
// on every element of a run when the empty-slot count differed from the second
// array's length. Requests pass a four-entry queue; the merge engine takes each
// load as it pops it in the idle state, and a run passes from the idle state into
// the merge state, whose rate is set by the single read port of each store. Each
// result is registered on the master channel. Counts are cleared after every run.
// A stalled receiver holds the merge in place; the queue keeps accepting requests
// until it is full. Reset empties the queue and clears all counts.
module compact_and_merge_sorted_arrays (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    input  logic signed [cmsa_pkg::VALUE_W-1:0] i_s_tdata,  // value
    input  logic [cmsa_pkg::ACTION_W-1:0]     i_s_tuser,  // action
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    output logic signed [cmsa_pkg::VALUE_W-1:0] o_m_tdata,  // merged_value
    output logic                              o_m_tlast,
    output logic                              o_m_tuser   // count_mismatch
);
    import cmsa_pkg::*;

    t_queue_head head;
    logic        pop;

    cmsa_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_head     (head),
        .i_pop      (pop)
    );

    cmsa_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_head     (head),
        .o_pop      (pop),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast),
        .o_m_tuser  (o_m_tuser)
    );

endmodule

>>> tb/tb_compact_and_merge_sorted_arrays.sv
// Testbench for compact_and_merge_sorted_arrays: directed and random load and run requests,
// with a scoreboard class that predicts every merged element and checks the master channel.
// Depends on cmsa_pkg and the RTL of compact_and_merge_sorted_arrays.
`timescale 1ns / 100ps

module tb_compact_and_merge_sorted_arrays;
    import cmsa_pkg::*;

    localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;
    localparam int DIRECTED_ITEMS = 21;
    localparam int RANDOM_ITEMS = 160;
    localparam int CALM_ITEMS = 40;
    localparam int DRAIN_CYCLES = 20;

    typedef struct {
        logic signed [VALUE_W-1:0] merged_value;
        logic last;
        logic count_mismatch;
    } t_merged_beat;

    class merge_scoreboard;
        int kept_vals[$];
        int second_vals[$];
        int unsigned slot_total;
        t_merged_beat pending_merged[$];
        int failures;
        int result_index;

        function new();
            slot_total = 0;
            failures = 0;
            result_index = 0;
        endfunction

        function void note_request(logic [ACTION_W-1:0] act, logic signed [VALUE_W-1:0] v);
            int a;
            int b;
            bit take_first;
            bit flag;
            t_merged_beat beat;
            case (act)
                ACT_LOAD_FIRST: begin
                    if (slot_total < FIRST_DEPTH) begin
                        slot_total++;
                        if (v != EMPTY_MARK) kept_vals.push_back(v);
                    end
                end
                ACT_LOAD_SECOND: begin
                    if (second_vals.size() < SECOND_DEPTH) second_vals.push_back(v);
                end
                ACT_RUN: begin
                    a = 0;
                    b = 0;
                    flag = (slot_total - kept_vals.size()) != second_vals.size();
                    while (a + b < kept_vals.size() + second_vals.size()) begin
                        take_first = a < kept_vals.size() &&
                                     (b >= second_vals.size() || kept_vals[a] <= second_vals[b]);
                        if (take_first) begin
                            beat.merged_value = kept_vals[a];
                            a++;
                        end else begin
                            beat.merged_value = second_vals[b];
                            b++;
                        end
                        beat.last = (a + b == kept_vals.size() + second_vals.size());
                        beat.count_mismatch = flag;
                        pending_merged.push_back(beat);
                    end
                    kept_vals.delete();
                    second_vals.delete();
                    slot_total = 0;
                end
                default: begin
                end
            endcase
        endfunction

        function void note_failure(string what);
            failures++;
            if (failures <= 10) $display("ERROR result %0d: %s", result_index, what);
        endfunction

        function void check_merged(logic signed [VALUE_W-1:0] v, logic last, logic flag);
            t_merged_beat want;
            if (pending_merged.size() == 0) begin
                note_failure($sformatf("unexpected result value %0d last %0b flag %0b",
                                       v, last, flag));
            end else begin
                want = pending_merged.pop_front();
                if (v !== want.merged_value)
                    note_failure($sformatf("merged_value expected %0d got %0d",
                                           want.merged_value, v));
                if (last !== want.last)
                    note_failure($sformatf("last expected %0b got %0b", want.last, last));
                if (flag !== want.count_mismatch)
                    note_failure($sformatf("count_mismatch expected %0b got %0b",
                                           want.count_mismatch, flag));
            end
            result_index++;
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    logic i_s_tvalid;
    logic o_s_tready;
    logic signed [VALUE_W-1:0] i_s_tdata;  // value
    logic [ACTION_W-1:0] i_s_tuser;        // action
    logic o_m_tvalid;
    logic i_m_tready;
    logic signed [VALUE_W-1:0] o_m_tdata;  // merged_value
    logic o_m_tlast;
    logic o_m_tuser;                       // count_mismatch

    merge_scoreboard merge_sb = new();
    bit calm = 1'b0;
    int sent_items = 0;

    compact_and_merge_sorted_arrays dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast),
        .o_m_tuser  (o_m_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #10000000;
        $display("compact_and_merge_sorted_arrays: mismatch");
        $finish;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_s_tvalid && o_s_tready) merge_sb.note_request(i_s_tuser, i_s_tdata);
            if (o_m_tvalid && i_m_tready) merge_sb.check_merged(o_m_tdata, o_m_tlast, o_m_tuser);
        end
    end

    initial begin
        i_m_tready <= 1'b1;
        forever begin
            @(posedge i_clk);
            if (!calm && $urandom_range(0, 7) == 0) begin
                i_m_tready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge i_clk);
                i_m_tready <= 1'b1;
            end
        end
    end

    task automatic send_request(logic [ACTION_W-1:0] act, logic [VALUE_W-1:0] v);
        if (!calm && $urandom_range(0, 3) == 0) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser <= act;
        i_s_tdata <= v;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        if (act != ACT_UNUSED) sent_items++;
    endtask

    function automatic int pick_value(bit narrow);
        if (narrow) return int'($urandom_range(0, 7)) - 4;
        return int'($urandom());
    endfunction

    // Sends one job: a first array with empty slots and a sorted second array, the two
    // streams interleaved at random, followed by a run request.
    task automatic send_merge_job(int n_first, int n_empty, int n_second, bit narrow);
        int kept[$];
        int second[$];
        int v;
        int left_kept;
        int left_empty;
        int ka;
        int sb;
        for (int i = 0; i < n_first - n_empty; i++) begin
            v = pick_value(narrow);
            if (v == -1) v = 0;
            kept.push_back(v);
        end
        for (int i = 0; i < n_second; i++) second.push_back(pick_value(narrow));
        kept.sort();
        second.sort();
        left_kept = kept.size();
        left_empty = n_empty;
        ka = 0;
        sb = 0;
        while (left_kept + left_empty > 0 || sb < second.size()) begin
            if (left_kept + left_empty > 0 &&
                (sb >= second.size() || $urandom_range(0, 1) == 0)) begin
                if (left_empty > 0 &&
                    (left_kept == 0 ||
                     $urandom_range(0, left_kept + left_empty - 1) < left_empty)) begin
                    send_request(ACT_LOAD_FIRST, EMPTY_MARK);
                    left_empty--;
                end else begin
                    send_request(ACT_LOAD_FIRST, kept[ka]);
                    ka++;
                    left_kept--;
                end
            end else begin
                send_request(ACT_LOAD_SECOND, second[sb]);
                sb++;
            end
        end
        send_request(ACT_RUN, $urandom());
    endtask

    initial begin
        int r;
        int n_first;
        int n_empty;
        int n_second;
        int seq_index;
        i_rst_n <= 1'b0;
        i_s_tvalid <= 1'b0;
        i_s_tdata <= '0;
        i_s_tuser <= ACT_LOAD_FIRST;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_request(ACT_RUN, 32'h0000_0000);
        send_request(ACT_UNUSED, 32'h5a5a_a5a5);
        send_request(ACT_LOAD_FIRST, 32'h8000_0000);
        send_request(ACT_LOAD_FIRST, EMPTY_MARK);
        send_request(ACT_LOAD_FIRST, 32'd5);
        send_request(ACT_LOAD_FIRST, EMPTY_MARK);
        send_request(ACT_LOAD_FIRST, 32'h7fff_ffff);
        send_request(ACT_LOAD_SECOND, 32'hffff_ffff);
        send_request(ACT_LOAD_SECOND, 32'd5);
        send_request(ACT_RUN, 32'hffff_ffff);
        send_request(ACT_LOAD_FIRST, EMPTY_MARK);
        send_request(ACT_LOAD_FIRST, EMPTY_MARK);
        send_request(ACT_LOAD_FIRST, 32'd3);
        send_request(ACT_LOAD_SECOND, 32'd3);
        send_request(ACT_RUN, 32'd0);
        send_request(ACT_LOAD_SECOND, 32'd10);
        send_request(ACT_RUN, 32'd0);
        send_request(ACT_LOAD_FIRST, EMPTY_MARK);
        send_request(ACT_RUN, 32'd0);
        send_request(ACT_LOAD_FIRST, 32'd0);
        send_request(ACT_RUN, 32'd0);

        seq_index = 0;
        while (sent_items < DIRECTED_ITEMS + RANDOM_ITEMS) begin
            if (sent_items >= DIRECTED_ITEMS + RANDOM_ITEMS - CALM_ITEMS) calm = 1'b1;
            r = $urandom_range(0, 99);
            if (seq_index == 0) begin
                // Both stores overflow and every slot holds a value: the longest run.
                send_merge_job(FIRST_DEPTH + 2, 0, SECOND_DEPTH + 2, 1'b0);
            end else if (r < 10) begin
                repeat ($urandom_range(1, 4))
                    send_request(ACTION_W'($urandom_range(0, 3)), $urandom());
            end else if (r < 25) begin
                n_first = $urandom_range(0, 8);
                n_empty = $urandom_range(0, n_first);
                send_merge_job(n_first, n_empty, $urandom_range(0, 8), $urandom_range(0, 2) == 0);
            end else begin
                n_first = (r >= 95) ? $urandom_range(9, FIRST_DEPTH) : $urandom_range(1, 8);
                n_empty = $urandom_range(0, n_first);
                n_second = n_empty;
                send_merge_job(n_first, n_empty, n_second, $urandom_range(0, 2) == 0);
            end
            seq_index++;
        end
        i_s_tvalid <= 1'b0;

        while (merge_sb.pending_merged.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (merge_sb.failures == 0 && merge_sb.pending_merged.size() == 0) begin
            $display("compact_and_merge_sorted_arrays: match");
        end else begin
            $display("compact_and_merge_sorted_arrays: mismatch");
        end
        $finish;
    end

endmodule
